### design/multistage_graph_shortest_path_top_defines.svh
// Assertion macros for the multistage graph shortest path block.
`ifndef MULTISTAGE_GRAPH_SHORTEST_PATH_TOP_DEFINES_SVH
`define MULTISTAGE_GRAPH_SHORTEST_PATH_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// expr must hold on every clock edge out of reset
`define MGSP_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mgsp: check failed");
// cons must hold on every edge where ante holds
`define MGSP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgsp: implication failed");
`else
`define MGSP_ASSERT(lbl, expr)
`define MGSP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### design/mgsp_pkg.sv
// Word types shared by the shortest path block and its users.
package mgsp_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] edge_weight;
        logic        edge_present;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  path_node;
        logic [19:0] total_cost;
        logic        no_path;
        logic        last;
    } out_item_t;

endpackage

### design/mgsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module mgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/multistage_graph_shortest_path_top.sv
// Top level: multistage graph shortest path, edge store plus backward DP sequencer.
//
// in_data words are accepted on in_valid && in_ready. A write word (op = 0) stores one
// edge {present, weight} and gives no result. A solve word (op = 1) runs the backward
// DP from the sink (node node_count-1) down to node 0, then emits the path from node 0
// to the sink, one out_data word per node, all carrying the total cost; last marks the
// sink word. An unreachable sink gives one word with no_path = 1.
// in_ready is high only while the sequencer is idle.
// A solve scans the candidate edges one at a time through the single edge RAM read port
// and one add/compare unit (an S_RD read state, then an S_EV evaluate state per edge),
// then emits each word through S_EMIT and S_HOP while out_ready stays high.
// The output register holds a word while out_ready is low; the sequencer waits for it.
// cfg_we writes node_count (reset 16, clamped to 2..MAX_NODES); write it only when idle.
// After reset the edge RAM is cleared one entry a cycle, all 2^(2*ceil(log2(MAX_NODES)))
// entries (256 at the defaults), with in_ready low; config writes are still taken.
`include "multistage_graph_shortest_path_top_defines.svh"
module multistage_graph_shortest_path_top #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mgsp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mgsp_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata
);

    import mgsp_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int EAW   = 2 * NW;
    localparam int EDEPTH = 1 << EAW;
    localparam int CW    = WEIGHT_BITS + NW;
    localparam int NCW   = (NW + 1 > 5) ? NW + 1 : 5;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SINK  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_HOP   = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [EAW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]   i_reg, i_next;
    logic [NW-1:0]   j_reg, j_next;
    logic [NW-1:0]   hop_reg, hop_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   best_reg, best_next;
    logic            found_reg, found_next;
    logic            nopath_reg, nopath_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;
    logic [4:0]      node_count_reg;

    logic [NCW-1:0]  nc_ext;
    logic [NCW-1:0]  n_act;
    logic [NW-1:0]   sink_idx;

    // edge RAM
    logic                   edge_we;
    logic [EAW-1:0]         edge_waddr;
    logic [WEIGHT_BITS:0]   edge_wdata;
    logic [EAW-1:0]         edge_raddr;
    logic [WEIGHT_BITS:0]   edge_rdata;

    // node cost RAM: {reach, cost}
    logic                   cost_we;
    logic [NW-1:0]          cost_waddr;
    logic [CW:0]            cost_wdata;
    logic [NW-1:0]          cost_raddr;
    logic [CW:0]            cost_rdata;

    // next hop RAM
    logic                   nhop_we;
    logic [NW-1:0]          nhop_waddr;
    logic [NW-1:0]          nhop_wdata;
    logic [NW-1:0]          nhop_raddr;
    logic [NW-1:0]          nhop_rdata;

    logic                   in_acc;
    logic                   wr_in_range;
    logic [NW-1:0]          from_idx;
    logic [NW-1:0]          to_idx;
    logic                   e_present;
    logic [CW-1:0]          cand;
    logic                   take;
    logic                   out_free;

    mgsp_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(EDEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    mgsp_ram #(.WIDTH(CW + 1), .DEPTH(MAX_NODES)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    mgsp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_hop_ram (
        .clk   (clk),
        .we    (nhop_we),
        .waddr (nhop_waddr),
        .wdata (nhop_wdata),
        .raddr (nhop_raddr),
        .rdata (nhop_rdata)
    );

    // node count clamped to 2..MAX_NODES
    assign nc_ext = NCW'(node_count_reg);
    always_comb
    begin
        if (nc_ext < NCW'(2))
        begin
            n_act = NCW'(2);
        end
        else if (nc_ext > NCW'(MAX_NODES))
        begin
            n_act = NCW'(MAX_NODES);
        end
        else
        begin
            n_act = nc_ext;
        end
    end
    assign sink_idx = NW'(n_act - NCW'(1));

    assign in_ready    = (state_reg == S_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign from_idx    = NW'(in_data.from_node);
    assign to_idx      = NW'(in_data.to_node);
    assign wr_in_range = ({28'd0, in_data.from_node} < MAX_NODES)
                      && ({28'd0, in_data.to_node} < MAX_NODES);

    // write port: clear sweep or loader word
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            edge_we    = 1'b1;
            edge_waddr = clr_cnt_reg;
            edge_wdata = '0;
        end
        else
        begin
            edge_we    = in_acc && (in_data.op == OP_WRITE) && wr_in_range;
            edge_waddr = {from_idx, to_idx};
            edge_wdata = {in_data.edge_present, WEIGHT_BITS'(in_data.edge_weight)};
        end
    end
    assign edge_raddr = {i_reg, j_reg};
    assign cost_raddr = j_reg;
    assign nhop_raddr = cur_reg;

    // shared add/compare unit
    assign e_present = edge_rdata[WEIGHT_BITS];
    assign cand      = CW'(edge_rdata[WEIGHT_BITS-1:0]) + cost_rdata[CW-1:0];
    assign take      = e_present && cost_rdata[CW] && (!found_reg || (cand < best_reg));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hop_next       = hop_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        nopath_next    = nopath_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cost_we        = 1'b0;
        cost_waddr     = i_reg;
        cost_wdata     = {found_reg, best_reg};
        nhop_we        = 1'b0;
        nhop_waddr     = i_reg;
        nhop_wdata     = hop_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + EAW'(1);
                if (clr_cnt_reg == EAW'(EDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && (in_data.op == OP_SOLVE))
                begin
                    state_next = S_SINK;
                end
            end
            S_SINK:
            begin
                cost_we    = 1'b1;
                cost_waddr = sink_idx;
                cost_wdata = {1'b1, {CW{1'b0}}};
                nhop_we    = 1'b1;
                nhop_waddr = sink_idx;
                nhop_wdata = sink_idx;
                i_next     = sink_idx - NW'(1);
                j_next     = sink_idx;
                best_next  = '0;
                found_next = 1'b0;
                hop_next   = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (take)
                begin
                    best_next  = cand;
                    found_next = 1'b1;
                    hop_next   = j_reg;
                end
                if (j_reg == sink_idx)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                cost_we = 1'b1;
                nhop_we = 1'b1;
                if (i_reg == '0)
                begin
                    nopath_next = !found_reg;
                    cur_next    = '0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg - NW'(1);
                    j_next     = i_reg;
                    best_next  = '0;
                    found_next = 1'b0;
                    hop_next   = '0;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                // best_reg still holds node 0's cost, zero when unreachable
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.path_node  = 4'(cur_reg);
                    out_data_next.total_cost = 20'(best_reg);
                    out_data_next.no_path    = nopath_reg;
                    out_data_next.last       = nopath_reg || (cur_reg == sink_idx);
                    if (nopath_reg || (cur_reg == sink_idx))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOP;
                    end
                end
            end
            S_HOP:
            begin
                cur_next   = nhop_rdata;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            node_count_reg <= 5'd16;
            i_reg          <= '0;
            j_reg          <= '0;
            cur_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cur_reg       <= cur_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hop_reg      <= hop_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        nopath_reg   <= nopath_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // scan stays inside the forward part of the current row
    `MGSP_ASSERT_IMPL(a_scan_in_row, state_reg == S_EV, (j_reg > i_reg) && (j_reg <= sink_idx))
    // a path only moves forward
    `MGSP_ASSERT_IMPL(a_hop_forward, state_reg == S_HOP, nhop_rdata > cur_reg)
    // unreachable sink gives one empty final word
    `MGSP_ASSERT_IMPL(a_nopath_word, out_valid_reg && out_data_reg.no_path, out_data_reg.last && (out_data_reg.path_node == 4'd0) && (out_data_reg.total_cost == 20'd0))
    // nothing leaves while the edge store is being cleared
    `MGSP_ASSERT_IMPL(a_clear_quiet, state_reg == S_CLEAR, !out_valid_reg)

endmodule
